[hdl/sgbc_pkg.sv]
// Shared definitions for the scatter-gather byte consume block.
// Holds action and status codes and the fixed field widths; no dependencies.
package sgbc_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 32;
    localparam int DROP_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_CONSUME = 2'd1,
        ACT_DROP    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DROP   = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

endpackage

[hdl/sgbc_in_if.sv]
// Input channel of the scatter-gather byte consume block: valid/ready plus one action.
// Depends on sgbc_pkg for the fixed field widths.
interface sgbc_in_if #(
    parameter int ADDR_WIDTH = 48,
    parameter int LEN_WIDTH  = 32
);
    logic                            valid;
    logic                            ready;
    logic [sgbc_pkg::ACTION_W-1:0]   action;
    logic [ADDR_WIDTH-1:0]           block_addr;
    logic [LEN_WIDTH-1:0]            block_len;
    logic [sgbc_pkg::BYTE_W-1:0]     byte_count;
    logic [sgbc_pkg::DROP_W-1:0]     drop_count;

    modport source (
        output valid, action, block_addr, block_len, byte_count, drop_count,
        input  ready
    );
    modport sink (
        input  valid, action, block_addr, block_len, byte_count, drop_count,
        output ready
    );
endinterface

[hdl/sgbc_out_if.sv]
// Result channel of the scatter-gather byte consume block: valid/ready plus one result.
// Depends on sgbc_pkg for the status width.
interface sgbc_out_if #(
    parameter int ADDR_WIDTH = 48,
    parameter int LEN_WIDTH  = 32,
    parameter int CNT_WIDTH  = 5
);
    logic                            valid;
    logic                            ready;
    logic [CNT_WIDTH-1:0]            blocks_removed;
    logic [CNT_WIDTH-1:0]            blocks_left;
    logic [ADDR_WIDTH-1:0]           head_addr;
    logic [LEN_WIDTH-1:0]            head_len;
    logic [sgbc_pkg::STATUS_W-1:0]   status;

    modport source (
        output valid, blocks_removed, blocks_left, head_addr, head_len, status,
        input  ready
    );
    modport sink (
        input  valid, blocks_removed, blocks_left, head_addr, head_len, status,
        output ready
    );
endinterface

[hdl/scatter_gather_byte_consume.sv]
// Top level of the scatter-gather byte consume block.
// Depends on sgbc_pkg and the channel interfaces sgbc_in_if and sgbc_out_if.
//
// This block keeps a ring of up to DEPTH scatter-gather descriptors (address and byte length)
// and performs one action per input transfer: push appends a descriptor at the tail, drop
// removes a number of head descriptors, and consume removes a byte count from the head,
// popping whole descriptors and then trimming the next one. Every input transfer produces
// exactly one result transfer that reports how many descriptors were removed, how many are
// left, the head descriptor afterwards (zeros when the ring is empty) and a status: push
// while full, drop of more than is held, and consume of bytes beyond all queued data are
// flagged. The block works on one transfer at a time and is not ready meanwhile. A push,
// a drop or an unused action passes through the start, head-read and done steps, and the
// result is registered in the done step before the block takes the next transfer. A consume
// adds a walk step for every descriptor it pops and one for the compare that ends the walk.
// The walk is paced by the descriptor memory, which is read at one address per cycle with
// registered read data, and by the single compare-and-subtract unit that the walk reuses.
// A result that is not taken holds the sequencer in its final step. The descriptor store
// is not cleared at reset; only slots holding a pushed descriptor are ever reported.
module scatter_gather_byte_consume #(
    parameter int DEPTH      = 16,
    parameter int ADDR_WIDTH = 48,
    parameter int LEN_WIDTH  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgbc_in_if.sink    i_in,
    sgbc_out_if.source o_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = (CNT_W > sgbc_pkg::DROP_W) ? CNT_W : sgbc_pkg::DROP_W;
    localparam int SUM_W = (ADDR_WIDTH > sgbc_pkg::BYTE_W) ? ADDR_WIDTH : sgbc_pkg::BYTE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_RDHEAD,
        S_DONE
    } t_state;

    // Descriptor memory, one write and one registered read port.
    logic [ADDR_WIDTH-1:0] r_mem_addr [DEPTH];
    logic [LEN_WIDTH-1:0]  r_mem_len  [DEPTH];
    logic [ADDR_WIDTH-1:0] r_rd_addr_data;
    logic [LEN_WIDTH-1:0]  r_rd_len_data;

    t_state                       r_state;
    logic [PTR_W-1:0]             r_head;
    logic [CNT_W-1:0]             r_count;
    logic [PTR_W-1:0]             r_ptr;
    logic [CNT_W-1:0]             r_i;
    logic [CNT_W-1:0]             r_removed;
    sgbc_pkg::t_status            r_status;
    sgbc_pkg::t_action            r_action;
    logic [ADDR_WIDTH-1:0]        r_in_addr;
    logic [LEN_WIDTH-1:0]         r_in_len;
    logic [sgbc_pkg::BYTE_W-1:0]  r_bytes;
    logic [sgbc_pkg::DROP_W-1:0]  r_drop;

    logic                         r_out_valid;
    logic [CNT_W-1:0]             r_out_removed;
    logic [CNT_W-1:0]             r_out_left;
    logic [ADDR_WIDTH-1:0]        r_out_addr;
    logic [LEN_WIDTH-1:0]         r_out_len;
    sgbc_pkg::t_status            r_out_status;

    // Memory port controls, driven by the sequencer.
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_idx;
    logic [ADDR_WIDTH-1:0] wr_addr_data;
    logic [LEN_WIDTH-1:0]  wr_len_data;
    logic [PTR_W-1:0]      rd_idx;

    // Ring arithmetic and the shared walk unit.
    logic [CNT_W-1:0]             adv_n;
    logic [CNT_W:0]               adv_sum;
    logic [PTR_W-1:0]             head_adv;
    logic [CNT_W:0]               tail_sum;
    logic [PTR_W-1:0]             tail_idx;
    logic [PTR_W-1:0]             ptr_next;
    logic [DW-1:0]                drop_ext;
    logic [DW-1:0]                count_ext;
    logic                         drop_over;
    logic [CNT_W-1:0]             drop_n;
    logic [sgbc_pkg::BYTE_W-1:0]  len_ext;
    logic                         bytes_ge;
    logic [sgbc_pkg::BYTE_W-1:0]  bytes_diff;
    logic [SUM_W-1:0]             addr_sum;
    logic                         in_xfer;
    logic                         out_free;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.blocks_removed = r_out_removed;
    assign o_out.blocks_left    = r_out_left;
    assign o_out.head_addr      = r_out_addr;
    assign o_out.head_len       = r_out_len;
    assign o_out.status         = r_out_status;

    // Drop clamps its count to the number of descriptors held.
    assign drop_ext  = DW'(r_drop);
    assign count_ext = DW'(r_count);
    assign drop_over = drop_ext > count_ext;
    assign drop_n    = drop_over ? r_count : CNT_W'(r_drop);

    // The head moves by the drop count or by the number of descriptors the walk popped.
    assign adv_n    = (r_state == S_START) ? drop_n : r_i;
    assign adv_sum  = (CNT_W+1)'(r_head) + (CNT_W+1)'(adv_n);
    assign head_adv = (adv_sum >= (CNT_W+1)'(DEPTH)) ? PTR_W'(adv_sum - (CNT_W+1)'(DEPTH))
                                                      : PTR_W'(adv_sum);

    assign tail_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
    assign tail_idx = (tail_sum >= (CNT_W+1)'(DEPTH)) ? PTR_W'(tail_sum - (CNT_W+1)'(DEPTH))
                                                       : PTR_W'(tail_sum);

    assign ptr_next = (r_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);

    // One compare and subtract serves every step of the consume walk.
    assign len_ext    = sgbc_pkg::BYTE_W'(r_rd_len_data);
    assign bytes_ge   = r_bytes >= len_ext;
    assign bytes_diff = r_bytes - len_ext;
    assign addr_sum   = SUM_W'(r_rd_addr_data) + SUM_W'(r_bytes);

    always_comb begin
        wr_en        = 1'b0;
        wr_idx       = tail_idx;
        wr_addr_data = r_in_addr;
        wr_len_data  = r_in_len;
        rd_idx       = r_head;
        unique case (r_state)
            S_START: begin
                rd_idx = r_ptr;
                if (r_action == sgbc_pkg::ACT_PUSH && r_count != CNT_W'(DEPTH)) begin
                    wr_en = 1'b1;
                end
            end
            S_WALK: begin
                rd_idx = ptr_next;
                if (r_i != r_count && !bytes_ge) begin
                    // Trim the descriptor where the walk stopped.
                    wr_en        = 1'b1;
                    wr_idx       = r_ptr;
                    wr_addr_data = addr_sum[ADDR_WIDTH-1:0];
                    wr_len_data  = r_rd_len_data - r_bytes[LEN_WIDTH-1:0];
                end
            end
            S_IDLE, S_RDHEAD, S_DONE: begin
                rd_idx = r_head;
            end
            default: begin
                rd_idx = r_head;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_addr[wr_idx] <= wr_addr_data;
            r_mem_len[wr_idx]  <= wr_len_data;
        end
        r_rd_addr_data <= r_mem_addr[rd_idx];
        r_rd_len_data  <= r_mem_len[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_action  <= sgbc_pkg::t_action'(i_in.action);
                        r_in_addr <= i_in.block_addr;
                        r_in_len  <= i_in.block_len;
                        r_bytes   <= i_in.byte_count;
                        r_drop    <= i_in.drop_count;
                        r_ptr     <= r_head;
                        r_i       <= '0;
                        r_removed <= '0;
                        r_status  <= sgbc_pkg::ST_OK;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    unique case (r_action)
                        sgbc_pkg::ACT_PUSH: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                r_status <= sgbc_pkg::ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_RDHEAD;
                        end
                        sgbc_pkg::ACT_DROP: begin
                            if (drop_over) begin
                                r_status <= sgbc_pkg::ST_DROP;
                            end
                            r_removed <= drop_n;
                            r_count   <= r_count - drop_n;
                            r_head    <= head_adv;
                            r_state   <= S_RDHEAD;
                        end
                        sgbc_pkg::ACT_CONSUME: begin
                            r_state <= S_WALK;
                        end
                        sgbc_pkg::ACT_NONE: begin
                            r_state <= S_RDHEAD;
                        end
                        default: begin
                            r_state <= S_RDHEAD;
                        end
                    endcase
                end
                S_WALK: begin
                    if (r_i != r_count && bytes_ge) begin
                        // Pop the whole descriptor and look at the next slot.
                        r_bytes <= bytes_diff;
                        r_i     <= r_i + CNT_W'(1);
                        r_ptr   <= ptr_next;
                    end else begin
                        if (r_i == r_count && r_bytes != '0) begin
                            r_status <= sgbc_pkg::ST_BEYOND;
                        end
                        r_removed <= r_i;
                        r_count   <= r_count - r_i;
                        r_head    <= head_adv;
                        r_state   <= S_RDHEAD;
                    end
                end
                S_RDHEAD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_removed <= r_removed;
                        r_out_left    <= r_count;
                        r_out_addr    <= (r_count != '0) ? r_rd_addr_data : '0;
                        r_out_len     <= (r_count != '0) ? r_rd_len_data : '0;
                        r_out_status  <= r_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[test/scatter_gather_byte_consume_tb.sv]
// Testbench for scatter_gather_byte_consume: directed and random descriptor actions,
// each result checked against an in-bench model of the descriptor ring.
// Depends on sgbc_pkg, sgbc_in_if, sgbc_out_if and the block itself.
`timescale 1ns / 1ps

module scatter_gather_byte_consume_tb;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 32;
    localparam int CNT_W       = 5;
    localparam int BYTE_W      = sgbc_pkg::BYTE_W;
    localparam int DROP_W      = sgbc_pkg::DROP_W;
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_OPS  = 1500;
    localparam int LONG_HOLD   = 150;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        sgbc_pkg::t_action     action;
        logic [ADDR_W-1:0]     block_addr;
        logic [LEN_W-1:0]      block_len;
        logic [BYTE_W-1:0]     byte_count;
        logic [DROP_W-1:0]     drop_count;
        logic                  wait_for_drain;
    } t_ring_op;

    typedef struct packed {
        logic [CNT_W-1:0]      blocks_removed;
        logic [CNT_W-1:0]      blocks_left;
        logic [ADDR_W-1:0]     head_addr;
        logic [LEN_W-1:0]      head_len;
        sgbc_pkg::t_status     status;
    } t_ring_report;

    logic clk = 1'b0;
    logic rst_n;

    sgbc_in_if  #(.ADDR_WIDTH(ADDR_W), .LEN_WIDTH(LEN_W))                   in_ch ();
    sgbc_out_if #(.ADDR_WIDTH(ADDR_W), .LEN_WIDTH(LEN_W), .CNT_WIDTH(CNT_W)) out_ch ();

    scatter_gather_byte_consume #(
        .DEPTH      (DEPTH),
        .ADDR_WIDTH (ADDR_W),
        .LEN_WIDTH  (LEN_W)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Model of the descriptor ring.
    logic [ADDR_W-1:0] ring_addr [DEPTH];
    logic [LEN_W-1:0]  ring_len  [DEPTH];
    int                ring_head = 0;
    int                ring_count = 0;

    t_ring_op     pending_ops [$];
    t_ring_report reports_due [$];
    t_ring_op     active_op;
    int           ops_accepted = 0;
    int           results_done = 0;
    int           mismatch_count = 0;
    int           send_gap = 0;
    int           recv_hold = 0;
    bit           sender_calm = 1'b0;
    bit           receiver_calm = 1'b0;
    int           quiet_cycles = 0;

    // Applies one action to the ring model and returns the report it should produce.
    function automatic t_ring_report step_ring(input t_ring_op op);
        t_ring_report rep;
        logic [BYTE_W-1:0] left_bytes;
        int walked;
        int slot;
        int n;
        rep = '0;
        rep.status = sgbc_pkg::ST_OK;
        n = 0;
        case (op.action)
            sgbc_pkg::ACT_PUSH: begin
                if (ring_count >= DEPTH) begin
                    rep.status = sgbc_pkg::ST_FULL;
                end else begin
                    slot = (ring_head + ring_count) % DEPTH;
                    ring_addr[slot] = op.block_addr;
                    ring_len[slot] = op.block_len;
                    ring_count++;
                end
            end
            sgbc_pkg::ACT_CONSUME: begin
                left_bytes = op.byte_count;
                walked = 0;
                slot = ring_head;
                // Whole descriptors go first, zero-length ones even with nothing left.
                while (walked < ring_count && left_bytes >= ring_len[slot]) begin
                    left_bytes -= ring_len[slot];
                    walked++;
                    slot = (slot + 1) % DEPTH;
                end
                if (walked < ring_count) begin
                    ring_addr[slot] = ring_addr[slot] + ADDR_W'(left_bytes);
                    ring_len[slot] = ring_len[slot] - LEN_W'(left_bytes);
                end else if (left_bytes != 0) begin
                    rep.status = sgbc_pkg::ST_BEYOND;
                end
                n = walked;
            end
            sgbc_pkg::ACT_DROP: begin
                n = op.drop_count;
                if (n > ring_count) begin
                    rep.status = sgbc_pkg::ST_DROP;
                    n = ring_count;
                end
            end
            default: ;
        endcase
        ring_head = (ring_head + n) % DEPTH;
        ring_count -= n;
        rep.blocks_removed = CNT_W'(n);
        rep.blocks_left = CNT_W'(ring_count);
        if (ring_count != 0) begin
            rep.head_addr = ring_addr[ring_head];
            rep.head_len = ring_len[ring_head];
        end
        return rep;
    endfunction

    function automatic t_ring_op make_op(input sgbc_pkg::t_action action,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [LEN_W-1:0] len,
                                         input logic [BYTE_W-1:0] bytes,
                                         input logic [DROP_W-1:0] drop);
        t_ring_op op;
        op.action = action;
        op.block_addr = addr;
        op.block_len = len;
        op.byte_count = bytes;
        op.drop_count = drop;
        op.wait_for_drain = 1'b0;
        return op;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 3) == 0)
            return {16'hFFFF, 32'hFFFF_FF00 | 32'($urandom_range(0, 255))};
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_W'($urandom);
            2: return '1;
            default: return LEN_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_bytes();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return BYTE_W'($urandom);
            2: return '1;
            3: return BYTE_W'(1);
            default: return BYTE_W'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [DROP_W-1:0] rand_drop();
        case ($urandom_range(0, 9))
            0: return DROP_W'($urandom_range(17, 31));
            1, 2: return DROP_W'($urandom_range(5, 16));
            default: return DROP_W'($urandom_range(0, 4));
        endcase
    endfunction

    // Push-heavy phases fill the ring, consume-heavy phases walk it down again.
    function automatic t_ring_op rand_op(input int push_pct);
        t_ring_op op;
        int pick;
        sgbc_pkg::t_action action;
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            action = sgbc_pkg::ACT_PUSH;
        else if (pick < 96)
            action = ($urandom_range(0, 3) != 0) ? sgbc_pkg::ACT_CONSUME : sgbc_pkg::ACT_DROP;
        else
            action = sgbc_pkg::ACT_NONE;
        op = make_op(action, rand_addr(), rand_len(), rand_bytes(), rand_drop());
        op.wait_for_drain = ($urandom_range(0, 149) == 0);
        return op;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: offers queued actions, idling a random number of cycles after each transfer.
    always @(posedge clk) begin : drive_ops
        logic offer;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.action <= sgbc_pkg::ACT_NONE;
            in_ch.block_addr <= '0;
            in_ch.block_len <= '0;
            in_ch.byte_count <= '0;
            in_ch.drop_count <= '0;
            send_gap = 0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                reports_due.push_back(step_ring(active_op));
                ops_accepted++;
                offer = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    sender_calm = !sender_calm;
                send_gap = sender_calm ? 0 : $urandom_range(0, 7);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].wait_for_drain && results_done != ops_accepted)) begin
                    active_op = pending_ops.pop_front();
                    in_ch.action <= active_op.action;
                    in_ch.block_addr <= active_op.block_addr;
                    in_ch.block_len <= active_op.block_len;
                    in_ch.byte_count <= active_op.byte_count;
                    in_ch.drop_count <= active_op.drop_count;
                    offer = 1'b1;
                end
            end
            in_ch.valid <= offer;
        end
    end

    // Receiver: checks each report and stalls at random; twice it holds off for a long time.
    always @(posedge clk) begin : take_reports
        t_ring_report want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_done <= results_done + 1;
                if (reports_due.size() == 0) begin
                    $error("report transfer with nothing outstanding");
                    mismatch_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("blocks_removed", 64'(want.blocks_removed),
                                64'(out_ch.blocks_removed));
                    check_field("blocks_left", 64'(want.blocks_left), 64'(out_ch.blocks_left));
                    check_field("head_addr", 64'(want.head_addr), 64'(out_ch.head_addr));
                    check_field("head_len", 64'(want.head_len), 64'(out_ch.head_len));
                    check_field("status", 64'(want.status), 64'(out_ch.status));
                end
                if ($urandom_range(0, 39) == 0)
                    receiver_calm = !receiver_calm;
                if (results_done + 1 == 200 || results_done + 1 == 900)
                    recv_hold = LONG_HOLD;
                else
                    recv_hold = receiver_calm ? 0 : $urandom_range(0, 7);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] fill_bytes;
        logic [LEN_W-1:0] len;
        t_ring_op op;
        int push_pct;

        rst_n = 1'b0;

        // Empty ring: consume nothing, consume beyond data, drops, unused action.
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '0, '0, '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '1, '1, BYTE_W'(7), '1));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_DROP, '0, '0, '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_DROP, '0, '0, '0, 5'd31));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_NONE, '1, '1, '1, '1));
        // Address wrap on trim, then a consume that also pops a zero-length descriptor.
        pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, 48'hFFFF_FFFF_FFF0, LEN_W'(32),
                                      '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, '0, '0, '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, '1, '1, '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '0, '0, BYTE_W'(20), '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '0, '0, BYTE_W'(12), '0));
        // Zero-length descriptor brought to the head, then popped by a zero-byte consume.
        pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, rand_addr(), '0, '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_DROP, '0, '0, '0, DROP_W'(1)));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '0, '0, '0, '0));
        // Fill the ring, push once more while full, then consume exactly all data.
        fill_bytes = '0;
        for (int k = 0; k < DEPTH; k++) begin
            len = LEN_W'($urandom_range(1, 1000));
            fill_bytes += len;
            pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, rand_addr(), len, '0, '0));
        end
        pending_ops.push_back(make_op(sgbc_pkg::ACT_PUSH, rand_addr(), rand_len(), '0, '0));
        pending_ops.push_back(make_op(sgbc_pkg::ACT_CONSUME, '0, '0, fill_bytes, '0));

        push_pct = 50;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (k % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 30;
                    1: push_pct = 50;
                    default: push_pct = 75;
                endcase
            end
            op = rand_op(push_pct);
            if (k == 0)
                op.wait_for_drain = 1'b1;
            pending_ops.push_back(op);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (pending_ops.size() != 0 || in_ch.valid || reports_due.size() != 0);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/sgbc_pkg.sv
hdl/sgbc_in_if.sv
hdl/sgbc_out_if.sv
hdl/scatter_gather_byte_consume.sv
test/scatter_gather_byte_consume_tb.sv
